// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold whenever the antecedent holds, outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// In the cycle after the antecedent, the consequent holds; checked during reset too.
`define ASSERT_NEXT_ANY(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/bhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared sizes, codes and types of the priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

   localparam int CAPACITY   = 16;
   localparam int VALUE_W    = 32;
   localparam int COUNT_W    = $clog2(CAPACITY + 1);
   localparam int RSP_DATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [COUNT_W-1:0]        count_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      MODE_MAX = 1'b0,
      MODE_MIN = 1'b1
   } order_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic      insert;
      logic      remove;
      order_type mode;
      value_type value;
   } cell_cmd_type;

   // Contents of one cell.
   typedef struct packed {
      logic      valid;
      value_type value;
   } slot_type;

endpackage

// ----- sv/binary_heap_priority_queue.sv -----
// A result appears in the cycle after its request transfer.
// Throughput: one request per cycle while results are taken; every cell of the
// chain settles its next content combinationally, which sets this rate.
// A stalled result holds off the next request until it is taken.
// Reset (synchronous, active high) empties the queue and selects max-on-top.
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Bounded priority queue of signed values, kept sorted in a chain of cells.
// ----------------------------------------------------------------------------
// The elements sit in a row of cells ordered from the top (cell 0) down. On an
// insert the new value is broadcast to all cells; each cell compares it with
// what it holds, and the cells below the insertion point take the element of
// their upper neighbor, so the row stays sorted. On a remove every cell takes
// the element of its lower neighbor. The top is therefore always in cell 0,
// which is what a heap would report for the same sequence of operations.
//
// An insert into a full queue and a remove from an empty one leave the cells
// untouched and report their status. The order register is only honored while
// the queue is empty, so the row never needs to be reordered.
module binary_heap_priority_queue (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bhpq_pkg::VALUE_W-1:0]        req_tdata,   // [31:0] value
   input  logic                                req_tuser,   // [0] opcode
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bhpq_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [31:0] top_value,
                                                            // [36:32] count, rest zero
   output logic [1:0]                          rsp_tuser,   // [1:0] status
   // Configuration register: order_mode.
   input  logic                                csr_wr_en,
   input  logic                                csr_wr_data
);

   localparam int CAP = bhpq_pkg::CAPACITY;

   bhpq_pkg::order_type    mode_ff;
   bhpq_pkg::count_type    count_ff, count_in;
   logic                   rsp_valid_ff;
   bhpq_pkg::value_type    rsp_top_ff, rsp_top_in;
   bhpq_pkg::count_type    rsp_count_ff;
   bhpq_pkg::status_type   rsp_status_ff, status_in;

   logic                   accept;
   logic                   is_full, is_empty;
   bhpq_pkg::cell_cmd_type cmd;

   bhpq_pkg::slot_type     slot      [CAP];
   bhpq_pkg::slot_type     slot_next [CAP];
   logic                   take      [CAP];

   // A request is taken whenever the result register is free or being emptied.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign is_full  = (count_ff == bhpq_pkg::COUNT_W'(CAP));
   assign is_empty = (count_ff == '0);

   // Rejected operations never reach the cells.
   assign cmd.insert = accept && (req_tuser == bhpq_pkg::OP_INSERT) && !is_full;
   assign cmd.remove = accept && (req_tuser == bhpq_pkg::OP_REMOVE) && !is_empty;
   assign cmd.mode   = mode_ff;
   assign cmd.value  = bhpq_pkg::value_type'(req_tdata);

   for (genvar g = 0; g < CAP; g++) begin : g_cell
      bhpq_pkg::slot_type prev_slot, next_slot;
      logic               prev_take;

      if (g == 0) begin : g_head
         assign prev_slot = '0;
         assign prev_take = 1'b0;
      end else begin : g_mid
         assign prev_slot = slot[g-1];
         assign prev_take = take[g-1];
      end

      if (g == CAP - 1) begin : g_tail
         assign next_slot = '0;
      end else begin : g_body
         assign next_slot = slot[g+1];
      end

      bhpq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .prev_slot (prev_slot),
         .prev_take (prev_take),
         .next_slot (next_slot),
         .slot      (slot[g]),
         .take      (take[g]),
         .slot_next (slot_next[g])
      );
   end

   always_comb begin
      count_in  = count_ff;
      status_in = bhpq_pkg::ST_DONE;
      if (req_tuser == bhpq_pkg::OP_INSERT) begin
         if (is_full) begin
            status_in = bhpq_pkg::ST_FULL;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end else begin
         if (is_empty) begin
            status_in = bhpq_pkg::ST_EMPTY;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   // The top after this step is what cell 0 is about to hold; zero when empty.
   assign rsp_top_in = slot_next[0].valid ? slot_next[0].value : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= bhpq_pkg::MODE_MAX;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Mode changes are only accepted on an empty queue.
         if (csr_wr_en && is_empty) begin
            mode_ff <= bhpq_pkg::order_type'(csr_wr_data);
         end
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         rsp_top_ff    <= rsp_top_in;
         rsp_count_ff  <= count_in;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = bhpq_pkg::RSP_DATA_W'({rsp_count_ff, rsp_top_ff});
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ----- sv/bhpq_cell.sv -----
// ----------------------------------------------------------------------------
// bhpq_cell
// One slot of the sorted chain: keeps one element and trades with neighbors.
// ----------------------------------------------------------------------------
module bhpq_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  bhpq_pkg::cell_cmd_type  cmd,
   input  bhpq_pkg::slot_type      prev_slot,   // neighbor closer to the top
   input  logic                    prev_take,   // that neighbor is empty or is beaten by the new value
   input  bhpq_pkg::slot_type      next_slot,   // neighbor farther from the top
   output bhpq_pkg::slot_type      slot,
   output logic                    take,
   output bhpq_pkg::slot_type      slot_next
);

   logic                valid_ff, valid_in;
   bhpq_pkg::value_type value_ff, value_in;
   logic                beats;

   // The new value ranks strictly above the one held here.
   assign beats = (cmd.mode == bhpq_pkg::MODE_MIN) ? (cmd.value < value_ff)
                                                   : (cmd.value > value_ff);
   assign take  = !valid_ff || beats;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (cmd.insert) begin
         if (prev_take) begin
            // The element above moves down to make room.
            valid_in = prev_slot.valid;
            value_in = prev_slot.value;
         end else if (take) begin
            valid_in = 1'b1;
            value_in = cmd.value;
         end
      end else if (cmd.remove) begin
         valid_in = next_slot.valid;
         value_in = next_slot.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign slot.valid      = valid_ff;
   assign slot.value      = value_ff;
   assign slot_next.valid = valid_in;
   assign slot_next.value = value_in;

endmodule

// ----- sv/bhpq_checker.sv -----
// ----------------------------------------------------------------------------
// bhpq_checker
// Port-level checks of the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bhpq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bhpq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]                      rsp_tuser
);

   localparam int COUNT_LSB = bhpq_pkg::VALUE_W;
   localparam int COUNT_MSB = bhpq_pkg::VALUE_W + bhpq_pkg::COUNT_W - 1;

   logic rsp_stalled;
   logic is_empty_rsp;
   logic is_full_rsp;

   assign rsp_stalled  = rsp_tvalid && !rsp_tready;
   assign is_empty_rsp = rsp_tvalid && (rsp_tuser == bhpq_pkg::ST_EMPTY);
   assign is_full_rsp  = rsp_tvalid && (rsp_tuser == bhpq_pkg::ST_FULL);

   // A stalled result keeps its payload.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")
   // Reset leaves no result pending.
   `ASSERT_NEXT_ANY(a_reset_clears, clock, reset, !rsp_tvalid, "result pending after reset")
   // No request transfer while a result is stuck in the output register.
   `ASSERT_IMPLY(a_no_overrun, clock, reset, req_tvalid && req_tready, !rsp_stalled, "request taken over stalled result")
   // A remove on an empty queue reports an empty queue with a zero top.
   `ASSERT_IMPLY(a_empty_rsp, clock, reset, is_empty_rsp, rsp_tdata == '0, "empty status with nonzero payload")
   // A full status reports a count equal to the capacity.
   `ASSERT_IMPLY(a_full_rsp, clock, reset, is_full_rsp, rsp_tdata[COUNT_MSB:COUNT_LSB] == bhpq_pkg::COUNT_W'(bhpq_pkg::CAPACITY), "full status below capacity")

endmodule

bind binary_heap_priority_queue bhpq_checker u_bhpq_checker (.*);
